FILE: src/qesf_pkg.sv
// Shared types, constants and node tables for the quadrilateral shape function evaluator.
package qesf_pkg;

	localparam int NODE_W       = 3;
	localparam int COORD_W      = 18;
	localparam int OUT_W        = 19;
	localparam int KIND_W       = 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN = -(2 ** (OUT_W - 1));

	// Element kind register codes.
	localparam logic [KIND_W-1:0] KIND_Q4 = 2'd0;
	localparam logic [KIND_W-1:0] KIND_Q5 = 2'd1;
	localparam logic [KIND_W-1:0] KIND_Q8 = 2'd2;

	// Node local coordinates: corners, then midsides (the Q5 center overrides node 4).
	localparam logic signed [1:0] NODE_XI  [8] = '{-2'sd1, 2'sd1, 2'sd1, -2'sd1,
		2'sd0, 2'sd1, 2'sd0, -2'sd1};
	localparam logic signed [1:0] NODE_ETA [8] = '{-2'sd1, -2'sd1, 2'sd1, 2'sd1,
		-2'sd1, 2'sd0, 2'sd1, 2'sd0};

	typedef enum logic [2:0] {
		OP_BAD,
		OP_Q4,
		OP_Q5_CORNER,
		OP_Q5_CENTER,
		OP_Q8_CORNER,
		OP_Q8_MID_X,
		OP_Q8_MID_Y
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic signed [1:0]         xi;
		logic signed [1:0]         eta;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} qesf_item_t;

endpackage

FILE: src/qesf_front.sv
// Front end: element kind register, command acceptance and node classification.
module qesf_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [qesf_pkg::NODE_W-1:0]        node_index,
	input  logic signed [qesf_pkg::COORD_W-1:0] point_x,
	input  logic signed [qesf_pkg::COORD_W-1:0] point_y,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [qesf_pkg::KIND_W-1:0]        cfg_data,
	input  logic                               q_full,
	output logic                               busy,
	output logic                               push,
	output qesf_pkg::qesf_item_t               item
);
	import qesf_pkg::*;

	logic [KIND_W-1:0] kind_q;
	op_t               op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_Q4;
		end else if (cfg_valid && cfg_ready) begin
			kind_q <= cfg_data;
		end
	end

	always_comb begin
		unique case (kind_q)
			KIND_Q4: begin
				op = (node_index < NODE_W'(4)) ? OP_Q4 : OP_BAD;
			end
			KIND_Q5: begin
				if (node_index < NODE_W'(4)) begin
					op = OP_Q5_CORNER;
				end else if (node_index == NODE_W'(4)) begin
					op = OP_Q5_CENTER;
				end else begin
					op = OP_BAD;
				end
			end
			KIND_Q8: begin
				if (node_index < NODE_W'(4)) begin
					op = OP_Q8_CORNER;
				end else if (node_index == NODE_W'(4) || node_index == NODE_W'(6)) begin
					op = OP_Q8_MID_X;
				end else begin
					op = OP_Q8_MID_Y;
				end
			end
			default: begin
				op = OP_BAD;
			end
		endcase
	end

	always_comb begin
		item.op  = op;
		item.xi  = NODE_XI[node_index];
		item.eta = NODE_ETA[node_index];
		item.x   = point_x;
		item.y   = point_y;
	end

	assign busy = q_full;
	assign push = start && !busy;

endmodule

FILE: src/qesf_queue.sv
// Small FIFO of classified items between the front end and the arithmetic pipeline.
module qesf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qesf_pkg::qesf_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 avail,
	output qesf_pkg::qesf_item_t pop_item
);
	import qesf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	qesf_item_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: src/qesf_back.sv
// Arithmetic pipeline: products, rounding, second product and saturation in six stages.
module qesf_back #(
	parameter int FRAC_BITS = qesf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  qesf_pkg::qesf_item_t                in_item,
	output logic                                done,
	output logic signed [qesf_pkg::OUT_W-1:0]   shape_value,
	output logic signed [qesf_pkg::OUT_W-1:0]   deriv_x,
	output logic signed [qesf_pkg::OUT_W-1:0]   deriv_y,
	output logic                                bad_node
);
	import qesf_pkg::*;

	// VW holds every operand of a first product, PW a first product, SW any rounded
	// result, MW the second product of the quadratic corner value.
	localparam int M1 = (FRAC_BITS > COORD_W - 1) ? FRAC_BITS : COORD_W - 1;
	localparam int M2 = (2 * COORD_W - 2 - FRAC_BITS > M1) ? 2 * COORD_W - 2 - FRAC_BITS : M1;
	localparam int VW = M2 + 3;
	localparam int PW = 2 * VW;
	localparam int SW = PW - FRAC_BITS + 3;
	localparam int MW = SW + VW;

	localparam logic signed [VW-1:0] ONE = {{(VW - 1){1'b0}}, 1'b1} << FRAC_BITS;

	// Shift right by s with rounding half toward plus infinity.
	function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] v, input int s);
		logic signed [MW:0] t;
		t = (MW + 1)'(v) + ((MW + 1)'(1) <<< (s - 1));
		return MW'(t >>> s);
	endfunction

	function automatic logic signed [VW-1:0] sgn_sel(input logic signed [1:0] c,
		input logic signed [VW-1:0] v);
		logic signed [VW-1:0] r;
		case (c)
			2'sd1:   r = v;
			-2'sd1:  r = -v;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SW'(OUT_MAX)) begin
			r = OUT_W'(OUT_MAX);
		end else if (v < SW'(OUT_MIN)) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: sign selections and squares.
	op_t                         op_s1;
	logic signed [1:0]           xi_s1, eta_s1;
	logic signed [VW-1:0]        x_s1, y_s1, sx_s1, sy_s1;
	logic signed [2*COORD_W-1:0] xx_s1, yy_s1;

	// Stage 2: linear factors.
	op_t                  op_s2;
	logic signed [1:0]    xi_s2, eta_s2;
	logic signed [VW-1:0] x_s2, y_s2, a_s2, b_s2, c_s2, d_s2, g_s2, h_s2, e_s2;

	// Stage 3: products.
	op_t                  op_s3;
	logic signed [PW-1:0] np_s3, bp_s3, xp_s3, yp_s3;
	logic signed [VW-1:0] linx_s3, liny_s3, e_s3;
	logic signed [VW-1:0] na, nb, xa, xb, ya, yb, linx, liny;

	// Stage 4: rounded partial results.
	op_t                  op_s4;
	logic signed [SW-1:0] n_s4, dx_s4, dy_s4;
	logic signed [VW-1:0] e_s4;
	logic signed [SW-1:0] n4, dx4, dy4, pn, pb, tx, ty;

	// Stage 5: quadratic corner product.
	op_t                  op_s5;
	logic signed [SW-1:0] n_s5, dx_s5, dy_s5;
	logic signed [MW-1:0] m_s5;

	// Stage 6: result registers.
	logic signed [OUT_W-1:0] shape_s6, dx_s6, dy_s6;
	logic                    bad_s6;
	logic signed [SW-1:0]    n6, dx6, dy6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= in_item.op;
		xi_s1  <= in_item.xi;
		eta_s1 <= in_item.eta;
		x_s1   <= VW'(in_item.x);
		y_s1   <= VW'(in_item.y);
		sx_s1  <= sgn_sel(in_item.xi, VW'(in_item.x));
		sy_s1  <= sgn_sel(in_item.eta, VW'(in_item.y));
		xx_s1  <= in_item.x * in_item.x;
		yy_s1  <= in_item.y * in_item.y;
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		xi_s2  <= xi_s1;
		eta_s2 <= eta_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		a_s2   <= ONE + sx_s1;
		b_s2   <= ONE + sy_s1;
		c_s2   <= ONE - VW'(rnd(MW'(xx_s1), FRAC_BITS));
		d_s2   <= ONE - VW'(rnd(MW'(yy_s1), FRAC_BITS));
		g_s2   <= (x_s1 <<< 1) + sgn_sel(xi_s1, sy_s1);
		h_s2   <= (y_s1 <<< 1) + sgn_sel(eta_s1, sx_s1);
		e_s2   <= sx_s1 + sy_s1 - ONE;
	end

	// Operand selection for the three product lanes; the bubble lane is always C*D.
	always_comb begin
		na   = a_s2;
		nb   = b_s2;
		xa   = x_s2;
		xb   = d_s2;
		ya   = y_s2;
		yb   = c_s2;
		linx = sgn_sel(xi_s2, b_s2);
		liny = sgn_sel(eta_s2, a_s2);
		unique case (op_s2)
			OP_Q8_CORNER: begin
				xa = b_s2;
				xb = g_s2;
				ya = a_s2;
				yb = h_s2;
			end
			OP_Q8_MID_X: begin
				na   = c_s2;
				xb   = b_s2;
				liny = sgn_sel(eta_s2, c_s2);
			end
			OP_Q8_MID_Y: begin
				nb   = d_s2;
				yb   = a_s2;
				linx = sgn_sel(xi_s2, d_s2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		np_s3   <= PW'(na) * PW'(nb);
		bp_s3   <= PW'(c_s2) * PW'(d_s2);
		xp_s3   <= PW'(xa) * PW'(xb);
		yp_s3   <= PW'(ya) * PW'(yb);
		linx_s3 <= linx;
		liny_s3 <= liny;
		e_s3    <= e_s2;
	end

	always_comb begin
		pn  = SW'(rnd(MW'(np_s3), FRAC_BITS));
		pb  = SW'(rnd(MW'(bp_s3), FRAC_BITS));
		tx  = SW'(rnd(MW'(xp_s3), FRAC_BITS));
		ty  = SW'(rnd(MW'(yp_s3), FRAC_BITS));
		n4  = '0;
		dx4 = '0;
		dy4 = '0;
		unique case (op_s3)
			OP_Q4: begin
				n4  = SW'(rnd(MW'(np_s3), FRAC_BITS + 2));
				dx4 = SW'(rnd(MW'(linx_s3), 2));
				dy4 = SW'(rnd(MW'(liny_s3), 2));
			end
			OP_Q5_CENTER: begin
				n4  = pb;
				dx4 = -(tx <<< 1);
				dy4 = -(ty <<< 1);
			end
			OP_Q5_CORNER: begin
				// The divide by four is applied in the last stage.
				n4  = pn - pb;
				dx4 = SW'(linx_s3) + (tx <<< 1);
				dy4 = SW'(liny_s3) + (ty <<< 1);
			end
			OP_Q8_CORNER: begin
				n4  = pn;
				dx4 = SW'(rnd(MW'(xp_s3), FRAC_BITS + 2));
				dy4 = SW'(rnd(MW'(yp_s3), FRAC_BITS + 2));
			end
			OP_Q8_MID_X: begin
				n4  = SW'(rnd(MW'(np_s3), FRAC_BITS + 1));
				dx4 = -tx;
				dy4 = SW'(rnd(MW'(liny_s3), 1));
			end
			OP_Q8_MID_Y: begin
				n4  = SW'(rnd(MW'(np_s3), FRAC_BITS + 1));
				dx4 = SW'(rnd(MW'(linx_s3), 1));
				dy4 = -ty;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s4 <= op_s3;
		n_s4  <= n4;
		dx_s4 <= dx4;
		dy_s4 <= dy4;
		e_s4  <= e_s3;
	end

	always_ff @(posedge clk) begin
		op_s5 <= op_s4;
		n_s5  <= n_s4;
		dx_s5 <= dx_s4;
		dy_s5 <= dy_s4;
		m_s5  <= MW'(n_s4) * MW'(e_s4);
	end

	always_comb begin
		n6  = n_s5;
		dx6 = dx_s5;
		dy6 = dy_s5;
		unique case (op_s5)
			OP_Q5_CORNER: begin
				n6  = SW'(rnd(MW'(n_s5), 2));
				dx6 = SW'(rnd(MW'(dx_s5), 2));
				dy6 = SW'(rnd(MW'(dy_s5), 2));
			end
			OP_Q8_CORNER: begin
				n6 = SW'(rnd(m_s5, FRAC_BITS + 2));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		shape_s6 <= sat(n6);
		dx_s6    <= sat(dx6);
		dy_s6    <= sat(dy6);
		bad_s6   <= (op_s5 == OP_BAD);
	end

	assign done        = v_s6;
	assign shape_value = shape_s6;
	assign deriv_x     = dx_s6;
	assign deriv_y     = dy_s6;
	assign bad_node    = bad_s6;

endmodule

FILE: src/quad_element_shape_function_eval_core.sv
// Top level of the quadrilateral element shape function evaluator (Q4, Q5, Q8).
//
//   Channel   Signals                                   Direction  Beat taken when
//   command   start, busy, node_index, point_x/y        in         start && !busy
//   result    done, shape_value, deriv_x/y, bad_node    out        done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data            in         cfg_valid && cfg_ready
//
// One command beat is taken every cycle while busy is low; each result comes out of the
// six-stage arithmetic pipeline behind the two-entry queue.
// The pipeline advances every cycle, so the queue drains as fast as it fills and busy
// stays low in operation. arst_n clears the element kind to the 4-node kind and empties
// the queue and pipeline; results cannot be held off by the receiver.
module quad_element_shape_function_eval_core #(
	parameter int FRAC_BITS = qesf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [qesf_pkg::NODE_W-1:0]         node_index,
	input  logic signed [qesf_pkg::COORD_W-1:0] point_x,
	input  logic signed [qesf_pkg::COORD_W-1:0] point_y,
	output logic                                done,
	output logic signed [qesf_pkg::OUT_W-1:0]   shape_value,
	output logic signed [qesf_pkg::OUT_W-1:0]   deriv_x,
	output logic signed [qesf_pkg::OUT_W-1:0]   deriv_y,
	output logic                                bad_node,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qesf_pkg::KIND_W-1:0]         cfg_data
);
	import qesf_pkg::*;

	localparam int CMD_TO_DONE = 7;

	qesf_item_t front_item;
	qesf_item_t back_item;
	logic       q_push;
	logic       q_full;
	logic       q_avail;

	qesf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.node_index (node_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.busy       (busy),
		.push       (q_push),
		.item       (front_item)
	);

	// The pipeline never stalls, so the queue head is taken whenever present.
	qesf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_avail),
		.avail     (q_avail),
		.pop_item  (back_item)
	);

	qesf_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_avail),
		.in_item     (back_item),
		.done        (done),
		.shape_value (shape_value),
		.deriv_x     (deriv_x),
		.deriv_y     (deriv_y),
		.bad_node    (bad_node)
	);

	a_cmd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##CMD_TO_DONE done)
		else $error("accepted command produced no result on time");

	a_result_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(arst_n && start && !busy, CMD_TO_DONE))
		else $error("result strobe without a matching command");

	a_bad_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_node |-> shape_value == '0 && deriv_x == '0 && deriv_y == '0)
		else $error("invalid node produced nonzero outputs");

	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue filled although the pipeline never stalls");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the quadrilateral element shape function evaluator.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qesf_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FRAC;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [NODE_W-1:0] NODE_LAST_CORNER = 3'd3;
	localparam logic [NODE_W-1:0] NODE_CENTER = 3'd4;
	localparam logic [NODE_W-1:0] NODE_MID_BOTTOM = 3'd4;
	localparam logic [NODE_W-1:0] NODE_MID_TOP = 3'd6;
	localparam int DRAIN_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
	localparam int COORD_MIN = -(2 ** (COORD_W - 1));

	typedef struct packed {
		logic signed [OUT_W-1:0] shape;
		logic signed [OUT_W-1:0] d_x;
		logic signed [OUT_W-1:0] d_y;
		logic                    bad;
	} shape_result_t;

	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic [NODE_W-1:0]         node;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		bit                        known;
		shape_result_t             result;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [NODE_W-1:0] node_index = '0;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic done;
	logic signed [OUT_W-1:0] shape_value;
	logic signed [OUT_W-1:0] deriv_x;
	logic signed [OUT_W-1:0] deriv_y;
	logic bad_node;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [KIND_W-1:0] cfg_data = '0;

	// Typed-in expectation that travels with the command beat, used instead of the predictor.
	bit typed_known = 1'b0;
	shape_result_t typed_result = '0;

	logic [KIND_W-1:0] kind_shadow = KIND_Q4;
	shape_result_t result_queue[$];
	directed_row_t directed_rows[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int idle_pct = 0;

	wire any_beat = (start && !busy) || done || (cfg_valid && cfg_ready);

	quad_element_shape_function_eval_core #(.FRAC_BITS(FRAC)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint round_down_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint mul_round(longint a, longint b, int s);
		return round_down_shift(a * b, s);
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
		if (v > OUT_MAX)
			return OUT_W'(OUT_MAX);
		if (v < OUT_MIN)
			return OUT_W'(OUT_MIN);
		return OUT_W'(v);
	endfunction

	function automatic shape_result_t eval_shape(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node,
			logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
		longint x, y, xi, eta, sx, sy, x2, y2, p, b, n, dx, dy;
		logic bad;
		shape_result_t r;
		x = px;
		y = py;
		n = 0;
		dx = 0;
		dy = 0;
		case (kind)
			KIND_Q4: bad = node > NODE_LAST_CORNER;
			KIND_Q5: bad = node > NODE_CENTER;
			KIND_Q8: bad = 1'b0;
			default: bad = 1'b1;
		endcase
		if (!bad) begin
			xi = NODE_XI[node];
			eta = NODE_ETA[node];
			if (kind == KIND_Q5 && node == NODE_CENTER) begin
				xi = 0;
				eta = 0;
			end
			sx = xi * x;
			sy = eta * y;
			x2 = mul_round(x, x, FRAC);
			y2 = mul_round(y, y, FRAC);
			if (kind == KIND_Q4) begin
				n = mul_round(ONE + sx, ONE + sy, FRAC + 2);
				dx = round_down_shift(xi * (ONE + sy), 2);
				dy = round_down_shift(eta * (ONE + sx), 2);
			end else if (kind == KIND_Q5) begin
				b = mul_round(ONE - x2, ONE - y2, FRAC);
				if (node == NODE_CENTER) begin
					n = b;
					dx = -2 * mul_round(x, ONE - y2, FRAC);
					dy = -2 * mul_round(y, ONE - x2, FRAC);
				end else begin
					// Corner functions of the bubble element subtract a quarter of the bubble.
					p = mul_round(ONE + sx, ONE + sy, FRAC);
					n = round_down_shift(p - b, 2);
					dx = round_down_shift(xi * (ONE + sy) + 2 * mul_round(x, ONE - y2, FRAC), 2);
					dy = round_down_shift(eta * (ONE + sx) + 2 * mul_round(y, ONE - x2, FRAC), 2);
				end
			end else begin
				if (node <= NODE_LAST_CORNER) begin
					p = mul_round(ONE + sx, ONE + sy, FRAC);
					n = mul_round(p, sx + sy - ONE, FRAC + 2);
					dx = mul_round(ONE + sy, 2 * x + xi * sy, FRAC + 2);
					dy = mul_round(ONE + sx, 2 * y + eta * sx, FRAC + 2);
				end else if (node == NODE_MID_BOTTOM || node == NODE_MID_TOP) begin
					n = mul_round(ONE - x2, ONE + sy, FRAC + 1);
					dx = -mul_round(x, ONE + sy, FRAC);
					dy = round_down_shift(eta * (ONE - x2), 1);
				end else begin
					n = mul_round(ONE + sx, ONE - y2, FRAC + 1);
					dx = round_down_shift(xi * (ONE - y2), 1);
					dy = -mul_round(y, ONE + sx, FRAC);
				end
			end
		end
		r.shape = clamp_out(n);
		r.d_x = clamp_out(dx);
		r.d_y = clamp_out(dy);
		r.bad = bad;
		return r;
	endfunction

	task automatic check_field(string label, logic signed [OUT_W-1:0] want,
			logic signed [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	// Result check, command capture and register shadow, all at the rising edge.
	always @(posedge clk) begin
		shape_result_t want;
		if (arst_n) begin
			if (done) begin
				if (result_queue.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, got %0d %0d %0d %0b",
						$time, shape_value, deriv_x, deriv_y, bad_node);
					mismatches++;
				end else begin
					want = result_queue.pop_front();
					check_field("shape_value", want.shape, shape_value);
					check_field("deriv_x", want.d_x, deriv_x);
					check_field("deriv_y", want.d_y, deriv_y);
					check_field("bad_node", {{(OUT_W-1){1'b0}}, want.bad},
						{{(OUT_W-1){1'b0}}, bad_node});
				end
			end
			if (start && !busy) begin
				if (typed_known)
					result_queue.push_back(typed_result);
				else
					result_queue.push_back(eval_shape(kind_shadow, node_index, point_x, point_y));
			end
			if (cfg_valid && cfg_ready)
				kind_shadow <= cfg_data;
		end
	end

	always @(posedge clk) begin
		if (any_beat || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic drive_item(logic [NODE_W-1:0] node, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, bit known, shape_result_t result);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		node_index <= node;
		point_x <= x;
		point_y <= y;
		typed_known <= known;
		typed_result <= result;
		do @(posedge clk); while (busy);
	endtask

	// Element kind changes only once every result is out and the pipeline has emptied.
	task automatic write_kind(logic [KIND_W-1:0] kind);
		@(negedge clk);
		start <= 1'b0;
		while (result_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= kind;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node, int x, int y,
			bit known, int n = 0, int dx = 0, int dy = 0, bit bad = 1'b0);
		directed_row_t row;
		row.kind = kind;
		row.node = node;
		row.x = COORD_W'(x);
		row.y = COORD_W'(y);
		row.known = known;
		row.result.shape = OUT_W'(n);
		row.result.d_x = OUT_W'(dx);
		row.result.d_y = OUT_W'(dy);
		row.result.bad = bad;
		directed_rows.push_back(row);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 75)
			return COORD_W'(int'($urandom_range(2 * ONE)) - int'(ONE));
		if (pick < 87)
			return COORD_W'($urandom());
		case ($urandom_range(6))
			0: return COORD_W'(COORD_MIN);
			1: return COORD_W'(COORD_MAX);
			2: return COORD_W'(-int'(ONE));
			3: return COORD_W'(int'(ONE));
			4: return COORD_W'(-1);
			5: return COORD_W'(1);
			default: return '0;
		endcase
	endfunction

	function automatic logic [NODE_W-1:0] rand_node(logic [KIND_W-1:0] kind);
		bit valid_pick;
		valid_pick = $urandom_range(99) < 85;
		case (kind)
			KIND_Q4: return NODE_W'(valid_pick ? $urandom_range(3) : $urandom_range(7, 4));
			KIND_Q5: return NODE_W'(valid_pick ? $urandom_range(4) : $urandom_range(7, 5));
			default: return NODE_W'($urandom_range(7));
		endcase
	endfunction

	initial begin
		logic [KIND_W-1:0] cur_kind;
		logic [KIND_W-1:0] seg_kinds[8];
		int seg_items[8];
		int seg_idle[3];
		directed_row_t row;

		seg_kinds = '{KIND_Q8, KIND_Q4, KIND_Q5, KIND_UNUSED, KIND_Q8, KIND_Q5, KIND_Q4, KIND_Q8};
		seg_items = '{100, 100, 100, 20, 100, 100, 100, 100};
		seg_idle = '{0, 50, 12};

		// Reset kind is the 4-node element, so the first rows run without a register write.
		add_row(KIND_Q4, 0, -65536, -65536, 1, 65536, -32768, -32768, 0);
		add_row(KIND_Q4, 0, 65536, 65536, 1, 0, 0, 0, 0);
		add_row(KIND_Q4, 2, 65536, 65536, 1, 65536, 32768, 32768, 0);
		add_row(KIND_Q4, 4, 0, 0, 1, 0, 0, 0, 1);
		add_row(KIND_Q4, 7, COORD_MAX, COORD_MIN, 1, 0, 0, 0, 1);
		add_row(KIND_Q4, 1, COORD_MAX, COORD_MIN, 0);
		add_row(KIND_Q4, 3, COORD_MIN, COORD_MAX, 0);
		add_row(KIND_Q5, 4, 0, 0, 1, 65536, 0, 0, 0);
		add_row(KIND_Q5, 5, 1000, -1000, 1, 0, 0, 0, 1);
		add_row(KIND_Q5, 7, COORD_MIN, COORD_MIN, 1, 0, 0, 0, 1);
		add_row(KIND_Q5, 0, 20000, -30000, 0);
		add_row(KIND_Q5, 4, COORD_MAX, COORD_MAX, 0);
		add_row(KIND_Q5, 2, COORD_MIN, COORD_MIN, 0);
		add_row(KIND_Q8, 0, -65536, -65536, 1, 65536, -98304, -98304, 0);
		add_row(KIND_Q8, 5, 65536, 0, 1, 65536, 32768, 0, 0);
		add_row(KIND_Q8, 4, 12345, -54321, 0);
		add_row(KIND_Q8, 6, COORD_MIN, COORD_MAX, 0);
		add_row(KIND_Q8, 7, COORD_MAX, COORD_MIN, 0);
		add_row(KIND_Q8, 3, COORD_MAX, COORD_MAX, 0);
		add_row(KIND_UNUSED, 0, 0, 0, 1, 0, 0, 0, 1);
		add_row(KIND_UNUSED, 4, 65536, -65536, 1, 0, 0, 0, 1);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		cur_kind = KIND_Q4;
		idle_pct = 12;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind != cur_kind) begin
				write_kind(row.kind);
				cur_kind = row.kind;
			end
			drive_item(row.node, row.x, row.y, row.known, row.result);
		end

		for (int seg = 0; seg < 8; seg++) begin
			write_kind(seg_kinds[seg]);
			idle_pct = seg_idle[seg % 3];
			for (int k = 0; k < seg_items[seg]; k++)
				drive_item(rand_node(seg_kinds[seg]), rand_coord(), rand_coord(), 1'b0, '0);
		end

		@(negedge clk);
		start <= 1'b0;
		while (result_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
src/qesf_pkg.sv
src/qesf_front.sv
src/qesf_queue.sv
src/qesf_back.sv
src/quad_element_shape_function_eval_core.sv
verif/tb_top.sv
